// File: design/jsv_pkg.sv
// Shared types and constants for the JSON stream validator.
`timescale 1ns / 1ps
`default_nettype none
package jsv_pkg;

    localparam int MAX_NEST    = 64;
    localparam int STACK_DEPTH = MAX_NEST + 1;
    localparam int STACK_AW    = $clog2(STACK_DEPTH);
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_CONT = 2'd1;
    localparam logic [1:0] KIND_DOC  = 2'd2;
    localparam logic [1:0] KIND_ERR  = 2'd3;

    localparam logic [2:0] CLS_WS   = 3'd0;
    localparam logic [2:0] CLS_STRC = 3'd1;
    localparam logic [2:0] CLS_STR  = 3'd2;
    localparam logic [2:0] CLS_NUM  = 3'd3;
    localparam logic [2:0] CLS_LIT  = 3'd4;
    localparam logic [2:0] CLS_NONE = 3'd5;

    localparam logic [4:0] E_NONE       = 5'd0;
    localparam logic [4:0] E_END_VALUE  = 5'd1;
    localparam logic [4:0] E_BAD_VALUE  = 5'd2;
    localparam logic [4:0] E_LITERAL    = 5'd3;
    localparam logic [4:0] E_NESTING    = 5'd4;
    localparam logic [4:0] E_TRAILING   = 5'd5;
    localparam logic [4:0] E_NEED_NAME  = 5'd6;
    localparam logic [4:0] E_NEED_COLON = 5'd7;
    localparam logic [4:0] E_END_OBJ    = 5'd8;
    localparam logic [4:0] E_OBJ_SEP    = 5'd9;
    localparam logic [4:0] E_END_ARR    = 5'd10;
    localparam logic [4:0] E_ARR_SEP    = 5'd11;
    localparam logic [4:0] E_OPEN_STR   = 5'd12;
    localparam logic [4:0] E_CTRL       = 5'd13;
    localparam logic [4:0] E_OPEN_ESC   = 5'd14;
    localparam logic [4:0] E_BAD_ESC    = 5'd15;
    localparam logic [4:0] E_SHORT_HEX  = 5'd16;
    localparam logic [4:0] E_BAD_HEX    = 5'd17;
    localparam logic [4:0] E_LONE_HIGH  = 5'd18;
    localparam logic [4:0] E_LONE_LOW   = 5'd19;
    localparam logic [4:0] E_DIGIT      = 5'd20;
    localparam logic [4:0] E_FRAC_DIGIT = 5'd21;
    localparam logic [4:0] E_EXP_DIGIT  = 5'd22;

    localparam logic [7:0] LIT_TEXT [16] = '{
        8'h74, 8'h72, 8'h75, 8'h65, 8'h66, 8'h61, 8'h6C, 8'h73,
        8'h65, 8'h6E, 8'h75, 8'h6C, 8'h6C, 8'h00, 8'h00, 8'h00
    };

    typedef struct packed {
        logic [7:0] byte_value;
        logic       is_end;
    } t_in;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         content_byte;
        logic               in_member_name;
        logic [2:0]         token_class;
        logic [DEPTH_W-1:0] nesting_level;
        logic [4:0]         error_code;
        logic               last_of_run;
    } t_out;

    // One request's worth of results, as queued between front and back.
    typedef struct packed {
        logic [2:0]         cnt;
        logic [3:0][7:0]    bytes;
        logic               ckey;
        logic [1:0]         kind;
        logic               skey;
        logic [2:0]         cls;
        logic [DEPTH_W-1:0] depth;
        logic [4:0]         err;
    } t_rec;

endpackage
`default_nettype wire

// File: design/json_stream_validator.sv
// Top level of the JSON stream validator.
// Takes one document byte (or the end marker) per request and checks JSON syntax
// with a container stack, decoding string content to UTF-8. The parser takes one
// request per clock while its 4-entry record queue has room; each request yields
// one record of 1 to 5 result items, and the result side delivers one item per
// clock while pop is asserted, so sustained throughput is set by the result port.
// A request's record enters the queue when taken. The user must write max_nesting
// through i_cfg_we/i_cfg_data while the block is idle; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none
module json_stream_validator (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire jsv_pkg::t_in  i_in,
    output logic               empty,
    input  wire logic          pop,
    output jsv_pkg::t_out      o_out,
    input  wire logic          i_cfg_we,
    input  wire logic [6:0]    i_cfg_data
);

    logic [6:0]    r_max_nest;
    logic          accept, rec_rd, rec_empty;
    jsv_pkg::t_rec wr_rec, rd_rec;

    assign accept = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_max_nest <= 7'(jsv_pkg::MAX_NEST);
        else if (i_cfg_we) r_max_nest <= i_cfg_data;
    end

    jsv_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_in       (i_in),
        .i_max_nest (r_max_nest),
        .o_rec      (wr_rec)
    );

    jsv_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (accept),
        .i_data  (wr_rec),
        .i_rd    (rec_rd),
        .o_data  (rd_rec),
        .o_full  (full),
        .o_empty (rec_empty)
    );

    jsv_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec       (rd_rec),
        .i_rec_empty (rec_empty),
        .i_pop       (pop),
        .o_rec_rd    (rec_rd),
        .o_out       (o_out),
        .o_empty     (empty)
    );

endmodule
`default_nettype wire

// File: design/jsv_front.sv
// Front end: parses one byte per request and builds its result record.
`timescale 1ns / 1ps
`default_nettype none
module jsv_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_accept,
    input  wire jsv_pkg::t_in   i_in,
    input  wire logic [6:0]     i_max_nest,
    output jsv_pkg::t_rec       o_rec
);

    typedef enum logic [4:0] {
        M_TOP, M_VALUE, M_ARR_FIRST, M_OBJ_FIRST, M_KEY, M_COLON, M_AFTER, M_DONE,
        M_STR, M_ESC, M_HEX1, M_PAIR_BS, M_PAIR_U, M_HEX2, M_LIT, M_NSIGN, M_NINT,
        M_NDOT, M_NFRAC, M_NE, M_NESIGN, M_NEXP, M_ERR
    } t_mode;

    typedef struct packed {
        logic [2:0]      cnt;
        logic [3:0][7:0] b;
    } t_utf;

    localparam int DW = jsv_pkg::DEPTH_W;
    localparam int AW = jsv_pkg::STACK_AW;

    function automatic t_utf utf8(input logic [20:0] cp);
        t_utf u;
        u.b = '0;
        if (cp < 21'h80) begin
            u.cnt  = 3'd1;
            u.b[0] = cp[7:0];
        end else if (cp < 21'h800) begin
            u.cnt  = 3'd2;
            u.b[0] = {3'b110, cp[10:6]};
            u.b[1] = {2'b10, cp[5:0]};
        end else if (cp < 21'h10000) begin
            u.cnt  = 3'd3;
            u.b[0] = {4'b1110, cp[15:12]};
            u.b[1] = {2'b10, cp[11:6]};
            u.b[2] = {2'b10, cp[5:0]};
        end else begin
            u.cnt  = 3'd4;
            u.b[0] = {5'b11110, cp[20:18]};
            u.b[1] = {2'b10, cp[17:12]};
            u.b[2] = {2'b10, cp[11:6]};
            u.b[3] = {2'b10, cp[5:0]};
        end
        return u;
    endfunction

    function automatic logic [4:0] hex_val(input logic [7:0] ch);
        logic [4:0] v;
        if (ch >= "0" && ch <= "9") v = 5'(ch - "0");
        else if (ch >= "a" && ch <= "f") v = 5'(ch - "a" + 8'd10);
        else if (ch >= "A" && ch <= "F") v = 5'(ch - "A" + 8'd10);
        else v = 5'd16;
        return v;
    endfunction

    t_mode          r_mode, n_mode;
    logic [DW-1:0]  r_depth, n_depth;
    logic           r_top, n_top;
    logic           r_below;
    logic [3:0]     r_prog, n_prog;
    logic [15:0]    r_acc, n_acc;
    logic [2:0]     r_hcnt, n_hcnt;
    logic [9:0]     r_hs, n_hs;
    logic           r_bad, n_bad;
    logic           r_key, n_key;
    logic [4:0]     r_held, n_held;

    logic           stack_mem [jsv_pkg::STACK_DEPTH];

    t_mode          md;
    logic [7:0]     c;
    logic [6:0]     lim;
    logic           ws, dig, is_e, obj;
    logic [4:0]     err, verdict, hx;
    logic [2:0]     cls, cnt;
    logic [3:0][7:0] cb;
    logic           do_start, do_close, do_push, push_obj;
    logic           h_bad, h_done;
    logic [15:0]    h_acc;
    logic [2:0]     h_cnt;
    t_utf           u_bmp, u_sup;
    logic [DW-1:0]  eff_depth;
    logic [AW-1:0]  rd_addr;
    jsv_pkg::t_rec  rec;

    assign c    = i_in.byte_value;
    assign lim  = (i_max_nest > 7'(jsv_pkg::MAX_NEST)) ? 7'(jsv_pkg::MAX_NEST) : i_max_nest;
    assign ws   = (c == " ") || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
    assign dig  = (c >= "0") && (c <= "9");
    assign is_e = (c == "e") || (c == "E");
    assign obj  = (r_depth != '0) && r_top;

    assign hx     = hex_val(c);
    assign h_bad  = r_bad | hx[4];
    assign h_acc  = hx[4] ? r_acc : {r_acc[11:0], hx[3:0]};
    assign h_cnt  = r_hcnt + 3'd1;
    assign h_done = (h_cnt >= 3'd4);
    assign u_bmp  = utf8({5'd0, h_acc});
    assign u_sup  = utf8(21'h10000 + {1'b0, r_hs, h_acc[9:0]});

    // End-marker verdict
    always_comb begin
        case (r_mode)
            M_TOP, M_VALUE, M_ARR_FIRST:
                verdict = (r_depth > DW'(lim)) ? jsv_pkg::E_NESTING : jsv_pkg::E_END_VALUE;
            M_OBJ_FIRST, M_KEY: verdict = jsv_pkg::E_NEED_NAME;
            M_COLON:            verdict = jsv_pkg::E_NEED_COLON;
            M_DONE:             verdict = jsv_pkg::E_NONE;
            M_AFTER, M_NINT, M_NFRAC, M_NEXP:
                verdict = (r_depth == '0) ? jsv_pkg::E_NONE :
                          (obj ? jsv_pkg::E_END_OBJ : jsv_pkg::E_END_ARR);
            M_STR:              verdict = jsv_pkg::E_OPEN_STR;
            M_ESC:              verdict = jsv_pkg::E_OPEN_ESC;
            M_HEX1, M_HEX2:     verdict = jsv_pkg::E_SHORT_HEX;
            M_PAIR_BS, M_PAIR_U: verdict = jsv_pkg::E_LONE_HIGH;
            M_LIT:              verdict = jsv_pkg::E_LITERAL;
            M_NSIGN:            verdict = jsv_pkg::E_DIGIT;
            M_NDOT:             verdict = jsv_pkg::E_FRAC_DIGIT;
            M_NE, M_NESIGN:     verdict = jsv_pkg::E_EXP_DIGIT;
            M_ERR:              verdict = r_held;
            default:            verdict = jsv_pkg::E_END_VALUE;
        endcase
    end

    // Byte parser
    always_comb begin
        n_mode = r_mode; n_depth = r_depth; n_top = r_top; n_prog = r_prog;
        n_acc = r_acc; n_hcnt = r_hcnt; n_hs = r_hs; n_bad = r_bad;
        n_key = r_key; n_held = r_held;
        err = jsv_pkg::E_NONE; cls = jsv_pkg::CLS_NONE; cnt = 3'd0; cb = '0;
        do_start = 1'b0; do_close = 1'b0; do_push = 1'b0; push_obj = 1'b0;

        md = r_mode;
        // a number ends at the first byte that cannot continue it
        if ((r_mode == M_NINT && !(dig || is_e || c == ".")) ||
            (r_mode == M_NFRAC && !(dig || is_e)) || (r_mode == M_NEXP && !dig)) begin
            md = (r_depth == '0) ? M_DONE : M_AFTER;
        end
        n_mode = md;

        if (ws && (md == M_TOP || md == M_VALUE || md == M_ARR_FIRST || md == M_OBJ_FIRST ||
                   md == M_KEY || md == M_COLON || md == M_AFTER || md == M_DONE)) begin
            cls = jsv_pkg::CLS_WS;
        end else begin
            case (md)
                M_TOP, M_VALUE: do_start = 1'b1;
                M_ARR_FIRST: begin
                    if (c == "]") do_close = 1'b1;
                    else do_start = 1'b1;
                end
                M_OBJ_FIRST, M_KEY: begin
                    if (md == M_OBJ_FIRST && c == "}") begin
                        do_close = 1'b1;
                    end else if (c == 8'h22) begin
                        n_mode = M_STR; n_key = 1'b1; cls = jsv_pkg::CLS_STR;
                    end else begin
                        err = jsv_pkg::E_NEED_NAME;
                    end
                end
                M_COLON: begin
                    if (c == ":") begin
                        n_mode = M_VALUE; cls = jsv_pkg::CLS_STRC;
                    end else begin
                        err = jsv_pkg::E_NEED_COLON;
                    end
                end
                M_AFTER: begin
                    if (c == ",") begin
                        n_mode = obj ? M_KEY : M_VALUE; cls = jsv_pkg::CLS_STRC;
                    end else if ((obj && c == "}") || (!obj && c == "]")) begin
                        do_close = 1'b1;
                    end else begin
                        err = obj ? jsv_pkg::E_OBJ_SEP : jsv_pkg::E_ARR_SEP;
                    end
                end
                M_DONE: err = jsv_pkg::E_TRAILING;
                M_STR: begin
                    cls = jsv_pkg::CLS_STR;
                    if (c == 8'h22) begin
                        n_mode = r_key ? M_COLON : ((r_depth == '0) ? M_DONE : M_AFTER);
                    end else if (c < 8'h20) begin
                        err = jsv_pkg::E_CTRL;
                    end else if (c == 8'h5C) begin
                        n_mode = M_ESC;
                    end else begin
                        cnt = 3'd1; cb[0] = c;
                    end
                end
                M_ESC: begin
                    cls = jsv_pkg::CLS_STR;
                    n_mode = M_STR;
                    cnt = 3'd1;
                    case (c)
                        8'h22, 8'h5C, "/": cb[0] = c;
                        "b": cb[0] = 8'h08;
                        "f": cb[0] = 8'h0C;
                        "n": cb[0] = 8'h0A;
                        "r": cb[0] = 8'h0D;
                        "t": cb[0] = 8'h09;
                        "u": begin
                            cnt = 3'd0; n_mode = M_HEX1;
                            n_acc = '0; n_hcnt = '0; n_bad = 1'b0;
                        end
                        default: begin
                            cnt = 3'd0; err = jsv_pkg::E_BAD_ESC;
                        end
                    endcase
                end
                M_HEX1, M_HEX2: begin
                    cls = jsv_pkg::CLS_STR;
                    n_bad = h_bad; n_acc = h_acc; n_hcnt = h_cnt;
                    if (h_done) begin
                        n_hcnt = '0;
                        if (h_bad) begin
                            err = jsv_pkg::E_BAD_HEX;
                        end else if (md == M_HEX1) begin
                            if (h_acc >= 16'hD800 && h_acc <= 16'hDBFF) begin
                                n_hs = h_acc[9:0]; n_mode = M_PAIR_BS;
                            end else if (h_acc >= 16'hDC00 && h_acc <= 16'hDFFF) begin
                                err = jsv_pkg::E_LONE_LOW;
                            end else begin
                                cnt = u_bmp.cnt; cb = u_bmp.b; n_mode = M_STR;
                            end
                        end else begin
                            if (h_acc < 16'hDC00 || h_acc > 16'hDFFF) begin
                                err = jsv_pkg::E_LONE_HIGH;
                            end else begin
                                cnt = u_sup.cnt; cb = u_sup.b; n_mode = M_STR;
                            end
                        end
                    end
                end
                M_PAIR_BS: begin
                    cls = jsv_pkg::CLS_STR;
                    if (c != 8'h5C) err = jsv_pkg::E_LONE_HIGH;
                    else n_mode = M_PAIR_U;
                end
                M_PAIR_U: begin
                    cls = jsv_pkg::CLS_STR;
                    if (c != "u") begin
                        err = jsv_pkg::E_LONE_HIGH;
                    end else begin
                        n_mode = M_HEX2; n_acc = '0; n_hcnt = '0; n_bad = 1'b0;
                    end
                end
                M_LIT: begin
                    cls = jsv_pkg::CLS_LIT;
                    if (jsv_pkg::LIT_TEXT[r_prog] != c || c == 8'h00) begin
                        err = jsv_pkg::E_LITERAL;
                    end else begin
                        n_prog = r_prog + 4'd1;
                        if (n_prog == 4'd4 || n_prog == 4'd9 || n_prog == 4'd13)
                            n_mode = (r_depth == '0) ? M_DONE : M_AFTER;
                    end
                end
                M_NSIGN: begin
                    cls = jsv_pkg::CLS_NUM;
                    if (!dig) err = jsv_pkg::E_DIGIT;
                    else n_mode = M_NINT;
                end
                M_NINT: begin
                    cls = jsv_pkg::CLS_NUM;
                    if (c == ".") n_mode = M_NDOT;
                    else if (is_e) n_mode = M_NE;
                end
                M_NDOT: begin
                    cls = jsv_pkg::CLS_NUM;
                    if (!dig) err = jsv_pkg::E_FRAC_DIGIT;
                    else n_mode = M_NFRAC;
                end
                M_NFRAC: begin
                    cls = jsv_pkg::CLS_NUM;
                    if (is_e) n_mode = M_NE;
                end
                M_NE: begin
                    cls = jsv_pkg::CLS_NUM;
                    if (c == "+" || c == "-") n_mode = M_NESIGN;
                    else if (!dig) err = jsv_pkg::E_EXP_DIGIT;
                    else n_mode = M_NEXP;
                end
                M_NESIGN: begin
                    cls = jsv_pkg::CLS_NUM;
                    if (!dig) err = jsv_pkg::E_EXP_DIGIT;
                    else n_mode = M_NEXP;
                end
                M_NEXP: cls = jsv_pkg::CLS_NUM;
                default: err = jsv_pkg::E_BAD_VALUE;
            endcase
        end

        if (do_start) begin
            if (r_depth > DW'(lim)) begin
                err = jsv_pkg::E_NESTING;
            end else begin
                case (c)
                    "{", "[": begin
                        if (r_depth >= DW'(jsv_pkg::STACK_DEPTH)) err = jsv_pkg::E_NESTING;
                        else begin
                            do_push = 1'b1; push_obj = (c == "{");
                        end
                    end
                    8'h22: begin
                        n_mode = M_STR; n_key = 1'b0; cls = jsv_pkg::CLS_STR;
                    end
                    "t": begin
                        n_prog = 4'd1; n_mode = M_LIT; cls = jsv_pkg::CLS_LIT;
                    end
                    "f": begin
                        n_prog = 4'd5; n_mode = M_LIT; cls = jsv_pkg::CLS_LIT;
                    end
                    "n": begin
                        n_prog = 4'd10; n_mode = M_LIT; cls = jsv_pkg::CLS_LIT;
                    end
                    default: begin
                        cls = jsv_pkg::CLS_NUM;
                        if (c == "-") n_mode = M_NSIGN;
                        else if (dig) n_mode = M_NINT;
                        else err = jsv_pkg::E_BAD_VALUE;
                    end
                endcase
            end
        end

        if (do_push) begin
            n_depth = r_depth + DW'(1);
            n_top   = push_obj;
            n_mode  = push_obj ? M_OBJ_FIRST : M_ARR_FIRST;
            cls     = jsv_pkg::CLS_STRC;
        end
        if (do_close) begin
            n_depth = (r_depth != '0) ? r_depth - DW'(1) : '0;
            n_top   = r_below;
            n_mode  = (n_depth == '0) ? M_DONE : M_AFTER;
            cls     = jsv_pkg::CLS_STRC;
        end
        if (err != jsv_pkg::E_NONE) begin
            n_mode = M_ERR; n_held = err; n_depth = r_depth; n_top = r_top;
        end
    end

    // Result record for this request
    always_comb begin
        rec = '0;
        if (i_in.is_end) begin
            rec.kind  = (verdict != jsv_pkg::E_NONE) ? jsv_pkg::KIND_ERR : jsv_pkg::KIND_DOC;
            rec.cls   = jsv_pkg::CLS_NONE;
            rec.depth = r_depth;
            rec.err   = verdict;
        end else if (r_mode == M_ERR) begin
            rec.kind  = jsv_pkg::KIND_ERR;
            rec.cls   = jsv_pkg::CLS_NONE;
            rec.depth = r_depth;
            rec.err   = r_held;
        end else if (err != jsv_pkg::E_NONE) begin
            rec.kind  = jsv_pkg::KIND_ERR;
            rec.cls   = jsv_pkg::CLS_NONE;
            rec.depth = r_depth;
            rec.err   = err;
        end else begin
            rec.kind  = jsv_pkg::KIND_BYTE;
            rec.cnt   = cnt;
            rec.bytes = cb;
            rec.ckey  = n_key;
            rec.skey  = (cls == jsv_pkg::CLS_STR) ? n_key : 1'b0;
            rec.cls   = cls;
            rec.depth = n_depth;
        end
    end
    assign o_rec = rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_TOP; r_depth <= '0; r_top <= 1'b0; r_prog <= '0;
            r_acc <= '0; r_hcnt <= '0; r_hs <= '0; r_bad <= 1'b0;
            r_key <= 1'b0; r_held <= '0;
        end else if (i_accept) begin
            if (i_in.is_end) begin
                // restart for the next document
                r_mode <= M_TOP; r_depth <= '0; r_top <= 1'b0; r_prog <= '0;
                r_acc <= '0; r_hcnt <= '0; r_hs <= '0; r_bad <= 1'b0;
                r_key <= 1'b0; r_held <= '0;
            end else if (r_mode != M_ERR) begin
                r_mode <= n_mode; r_depth <= n_depth; r_top <= n_top; r_prog <= n_prog;
                r_acc <= n_acc; r_hcnt <= n_hcnt; r_hs <= n_hs; r_bad <= n_bad;
                r_key <= n_key; r_held <= n_held;
            end
        end
    end

    // Container stack: the top entry lives in r_top, the one below it is
    // read ahead from memory so that a close can take it at once.
    always_comb begin
        if (!i_accept || r_mode == M_ERR) eff_depth = r_depth;
        else if (i_in.is_end) eff_depth = '0;
        else eff_depth = n_depth;
        rd_addr = (eff_depth >= DW'(2)) ? AW'(eff_depth - DW'(2)) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && !i_in.is_end && r_mode != M_ERR && do_push &&
            err == jsv_pkg::E_NONE) begin
            stack_mem[AW'(r_depth)] <= push_obj;
        end
        r_below <= stack_mem[rd_addr];
    end

endmodule
`default_nettype wire

// File: design/jsv_fifo.sv
// Short record queue between the parser and the result sequencer.
`timescale 1ns / 1ps
`default_nettype none
module jsv_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_wr,
    input  wire jsv_pkg::t_rec i_data,
    input  wire logic          i_rd,
    output jsv_pkg::t_rec      o_data,
    output logic               o_full,
    output logic               o_empty
);

    localparam int AW = jsv_pkg::FIFO_AW;

    jsv_pkg::t_rec      r_mem [jsv_pkg::FIFO_DEPTH];
    logic [AW-1:0]      r_wp, r_rp;
    logic [AW:0]        r_count;
    logic               wr_ok, rd_ok;

    assign o_full  = (r_count == (AW+1)'(jsv_pkg::FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_ok   = i_wr && !o_full;
    assign rd_ok   = i_rd && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_count <= '0;
        end else begin
            if (wr_ok) r_wp <= r_wp + AW'(1);
            if (rd_ok) r_rp <= r_rp + AW'(1);
            case ({wr_ok, rd_ok})
                2'b10:   r_count <= r_count + (AW+1)'(1);
                2'b01:   r_count <= r_count - (AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_ok) r_mem[r_wp] <= i_data;
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (AW+1)'(jsv_pkg::FIFO_DEPTH))
        else $error("queue count out of range");
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_ok && !rd_ok) |=> (r_count == $past(r_count) + (AW+1)'(1)))
        else $error("queue count did not grow on write");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0 && r_count != (AW+1)'(jsv_pkg::FIFO_DEPTH)) |-> (r_wp != r_rp))
        else $error("pointers meet while queue partly full");

endmodule
`default_nettype wire

// File: design/jsv_back.sv
// Back end: walks each queued record out as content items then a status item.
`timescale 1ns / 1ps
`default_nettype none
module jsv_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire jsv_pkg::t_rec i_rec,
    input  wire logic          i_rec_empty,
    input  wire logic          i_pop,
    output logic               o_rec_rd,
    output jsv_pkg::t_out      o_out,
    output logic               o_empty
);

    logic [2:0] r_idx;
    logic       is_status, take;

    assign is_status = (r_idx >= i_rec.cnt);
    assign o_empty   = i_rec_empty;
    assign take      = i_pop && !i_rec_empty;
    assign o_rec_rd  = take && is_status;

    always_comb begin
        o_out = '0;
        o_out.nesting_level = i_rec.depth;
        if (!is_status) begin
            o_out.kind           = jsv_pkg::KIND_CONT;
            o_out.content_byte   = i_rec.bytes[r_idx[1:0]];
            o_out.in_member_name = i_rec.ckey;
            o_out.token_class    = jsv_pkg::CLS_STR;
        end else begin
            o_out.kind           = i_rec.kind;
            o_out.in_member_name = i_rec.skey;
            o_out.token_class    = i_rec.cls;
            o_out.error_code     = i_rec.err;
            o_out.last_of_run    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (take) begin
            // advance through content bytes, drop the record after its status
            r_idx <= is_status ? 3'd0 : r_idx + 3'd1;
        end
    end

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_rec_empty |-> (r_idx <= i_rec.cnt))
        else $error("content index beyond record");
    a_idx_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rec_rd |=> (r_idx == 3'd0))
        else $error("index not cleared after status item");
    a_cont_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_out.kind == jsv_pkg::KIND_CONT) |->
            (o_out.error_code == 5'd0 && !o_out.last_of_run))
        else $error("content item carries status fields");

endmodule
`default_nettype wire
